// ----- src/ia2d_pkg.sv -----
// Shared types and constants for the integer atan2 (degrees) block.
package ia2d_pkg;

   // Port width of each coordinate and default coordinate width in use
   localparam int COORD_W        = 12;
   localparam int COORD_BITS_DEF = 12;

   // Octant quotient and result widths
   localparam int QUOT_BITS = 6;
   localparam int ANGLE_W   = 9;
   localparam int OCT_MAX   = 45;

   // Rational approximation gains: a*(OCT_B*b - OCT_A*a) / (DEN_GAIN*b*b)
   localparam int OCT_B    = 182;
   localparam int OCT_A    = 47;
   localparam int DEN_GAIN = 3;

   // Quadrant offsets in degrees
   localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
   localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
   localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
   localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

   // Sign and octant flags that travel alongside the division
   typedef struct packed {
      logic origin;   // both coordinates zero
      logic y_zero;   // point on the X axis
      logic y_neg;
      logic x_neg;
      logic swap;     // |x| > |y|, octant angle measured from the other axis
   } quad_type;

endpackage

// ----- src/integer_atan2_degrees.sv -----
// Top level of the integer atan2 block: point (y, x) to angle in whole degrees.
//
// Takes a signed point (y, x) and returns the angle from the origin in whole degrees,
// 0..359, with 0 for the origin. Coordinates are taken from the low COORD_BITS bits
// of each 12-bit port and read as two's complement. The octant angle is approximated as
// floor(a*(182b-47a)/(3b*b)) with a = min(|x|,|y|), b = max(|x|,|y|), then mapped
// to the quadrant. The pipeline is seven register stages deep: fold and sort, the
// squaring and linear term, the numerator product, three divider stages that each
// settle two bits of the six-bit quotient, and the output register that applies the
// quadrant offset. One point is accepted every cycle while the output is not stalled;
// a stalled result holds its stage while earlier empty stages keep filling.
module integer_atan2_degrees #(
   parameter int COORD_BITS = ia2d_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ia2d_pkg::COORD_W-1:0] req_y_coord,
   input  logic [ia2d_pkg::COORD_W-1:0] req_x_coord,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ia2d_pkg::ANGLE_W-1:0] rsp_angle_deg
);
   import ia2d_pkg::*;

   localparam int MAG_W = COORD_BITS;
   localparam int T_W   = COORD_BITS + 7;
   localparam int NUM_W = 2*COORD_BITS + 6;
   localparam int DEN_W = 2*COORD_BITS;

   // Front stage control
   logic [2:0]         front_valid_ff;
   logic [2:0]         front_load;
   logic               out_load;

   // Fold and sort
   logic [MAG_W-1:0]   y_raw, x_raw, y_mag, x_mag;
   logic [MAG_W-1:0]   min_in, max_in;
   quad_type           quad_in;
   logic [MAG_W-1:0]   s0_min_ff, s0_max_ff;
   quad_type           s0_quad_ff;

   // Linear term and square
   logic [T_W-1:0]     lin_in;
   logic [DEN_W-1:0]   sq_in;
   logic [MAG_W-1:0]   s1_min_ff;
   logic [T_W-1:0]     s1_lin_ff;
   logic [DEN_W-1:0]   s1_sq_ff;
   quad_type           s1_quad_ff;

   // Numerator and denominator
   logic [NUM_W-1:0]   num_in;
   logic [DEN_W-1:0]   den_in;
   logic [NUM_W-1:0]   s2_num_ff;
   logic [DEN_W-1:0]   s2_den_ff;
   quad_type           s2_quad_ff;

   // Divider and output
   logic               div_in_ready;
   logic               div_out_valid;
   logic [QUOT_BITS-1:0] div_quot;
   quad_type           div_quad;
   logic [ANGLE_W-1:0] rel_deg;
   logic [ANGLE_W-1:0] up_deg;
   logic [ANGLE_W-1:0] angle_in;
   logic               out_valid_ff;
   logic [ANGLE_W-1:0] angle_ff;

   // Load enables through the front stages
   assign out_load      = !out_valid_ff || rsp_ready;
   assign front_load[2] = !front_valid_ff[2] || div_in_ready;
   assign front_load[1] = !front_valid_ff[1] || front_load[2];
   assign front_load[0] = !front_valid_ff[0] || front_load[1];
   assign req_ready     = front_load[0];

   // Stage 0: sign fold, magnitude, octant sort
   always_comb begin
      y_raw          = req_y_coord[COORD_BITS-1:0];
      x_raw          = req_x_coord[COORD_BITS-1:0];
      y_mag          = y_raw[MAG_W-1] ? (~y_raw + MAG_W'(1)) : y_raw;
      x_mag          = x_raw[MAG_W-1] ? (~x_raw + MAG_W'(1)) : x_raw;
      quad_in.y_neg  = y_raw[MAG_W-1];
      quad_in.x_neg  = x_raw[MAG_W-1];
      quad_in.y_zero = (y_raw == '0);
      quad_in.origin = (y_raw == '0) && (x_raw == '0);
      quad_in.swap   = (x_mag > y_mag);
      min_in         = quad_in.swap ? y_mag : x_mag;
      max_in         = quad_in.swap ? x_mag : y_mag;
   end

   // Stage 1: 182b - 47a and b*b
   assign lin_in = (T_W'(s0_max_ff) * T_W'(OCT_B)) - (T_W'(s0_min_ff) * T_W'(OCT_A));
   assign sq_in  = DEN_W'(s0_max_ff) * DEN_W'(s0_max_ff);

   // Stage 2: numerator product and 3b*b
   assign num_in = NUM_W'(s1_min_ff) * NUM_W'(s1_lin_ff);
   assign den_in = s1_sq_ff * DEN_W'(DEN_GAIN);

   // Front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= '0;
      end else begin
         if (front_load[0]) begin
            front_valid_ff[0] <= req_valid;
         end
         if (front_load[1]) begin
            front_valid_ff[1] <= front_valid_ff[0];
         end
         if (front_load[2]) begin
            front_valid_ff[2] <= front_valid_ff[1];
         end
      end
   end

   // Front payload
   always_ff @(posedge clock) begin
      if (front_load[0] && req_valid) begin
         s0_min_ff  <= min_in;
         s0_max_ff  <= max_in;
         s0_quad_ff <= quad_in;
      end
      if (front_load[1] && front_valid_ff[0]) begin
         s1_min_ff  <= s0_min_ff;
         s1_lin_ff  <= lin_in;
         s1_sq_ff   <= sq_in;
         s1_quad_ff <= s0_quad_ff;
      end
      if (front_load[2] && front_valid_ff[1]) begin
         s2_num_ff  <= num_in;
         s2_den_ff  <= den_in;
         s2_quad_ff <= s1_quad_ff;
      end
   end

   ia2d_div #(
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid_ff[2]),
      .in_ready  (div_in_ready),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_quad   (s2_quad_ff),
      .out_valid (div_out_valid),
      .out_ready (out_load),
      .out_quot  (div_quot),
      .out_quad  (div_quad)
   );

   // Quadrant mapping: angle within the quadrant, then the offset
   always_comb begin
      rel_deg = div_quad.swap ? (DEG_90 - ANGLE_W'(div_quot)) : ANGLE_W'(div_quot);
      up_deg  = DEG_270 + rel_deg;
      priority if (div_quad.origin) begin
         angle_in = '0;
      end else if (div_quad.y_zero) begin
         angle_in = div_quad.x_neg ? DEG_180 : '0;
      end else if (!div_quad.y_neg) begin
         angle_in = div_quad.x_neg ? (DEG_90 + rel_deg) : (DEG_90 - rel_deg);
      end else if (div_quad.x_neg) begin
         angle_in = DEG_270 - rel_deg;
      end else begin
         // full turn wraps to zero
         angle_in = (up_deg == DEG_360) ? '0 : up_deg;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && div_out_valid) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_angle_deg = angle_ff;

   // Result always below a full turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angle_deg < DEG_360)
      else $error("angle out of range");

   // An accepted beat lands in the first stage
   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> front_valid_ff[0])
      else $error("accepted beat lost at entry");

   // Full front stages behind a stalled divider take nothing new
   a_front_stall: assert property (@(posedge clock) disable iff (reset)
      (&front_valid_ff) && !div_in_ready |-> !req_ready)
      else $error("beat accepted while the front is full");

endmodule

// ----- src/ia2d_div.sv -----
// Pipelined restoring divider for the octant quotient, two quotient bits per stage.
module ia2d_div #(
   parameter int COORD_BITS = ia2d_pkg::COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [2*COORD_BITS+5:0]        in_num,
   input  logic [2*COORD_BITS-1:0]        in_den,
   input  ia2d_pkg::quad_type             in_quad,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [ia2d_pkg::QUOT_BITS-1:0] out_quot,
   output ia2d_pkg::quad_type             out_quad
);
   import ia2d_pkg::*;

   localparam int NUM_W          = 2*COORD_BITS + 6;
   localparam int DEN_W          = 2*COORD_BITS;
   localparam int STAGES         = 3;
   localparam int BITS_PER_STAGE = QUOT_BITS / STAGES;

   logic [STAGES-1:0]    valid_ff;
   logic [STAGES-1:0]    load;
   logic [NUM_W-1:0]     rem_ff   [STAGES];
   logic [DEN_W-1:0]     den_ff   [STAGES];
   logic [QUOT_BITS-1:0] quot_ff  [STAGES];
   quad_type             quad_ff  [STAGES];

   logic [STAGES-1:0]    src_valid;
   logic [NUM_W-1:0]     src_rem  [STAGES];
   logic [DEN_W-1:0]     src_den  [STAGES];
   logic [QUOT_BITS-1:0] src_quot [STAGES];
   quad_type             src_quad [STAGES];

   logic [NUM_W-1:0]     rem_in   [STAGES];
   logic [QUOT_BITS-1:0] quot_in  [STAGES];

   logic [NUM_W-1:0]     rem_work;
   logic [QUOT_BITS-1:0] quot_work;
   logic [NUM_W-1:0]     trial;
   logic                 take;

   // Stage load enables: a stage loads when empty or when its beat moves on
   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int s = STAGES-2; s >= 0; s--) begin
         load[s] = !valid_ff[s] || load[s+1];
      end
   end

   assign in_ready = load[0];

   // Stage sources: first stage from the port, the rest from the stage before
   always_comb begin
      src_valid[0] = in_valid;
      src_rem[0]   = in_num;
      src_den[0]   = in_den;
      src_quot[0]  = '0;
      src_quad[0]  = in_quad;
      for (int s = 1; s < STAGES; s++) begin
         src_valid[s] = valid_ff[s-1];
         src_rem[s]   = rem_ff[s-1];
         src_den[s]   = den_ff[s-1];
         src_quot[s]  = quot_ff[s-1];
         src_quad[s]  = quad_ff[s-1];
      end
   end

   // Compare and subtract, MSB of the quotient first
   always_comb begin
      rem_work  = '0;
      quot_work = '0;
      trial     = '0;
      take      = 1'b0;
      for (int s = 0; s < STAGES; s++) begin
         rem_work  = src_rem[s];
         quot_work = src_quot[s];
         for (int k = 0; k < BITS_PER_STAGE; k++) begin
            trial = NUM_W'(src_den[s]) << (QUOT_BITS - 1 - s*BITS_PER_STAGE - k);
            take  = (rem_work >= trial);
            if (take) begin
               rem_work = rem_work - trial;
            end
            quot_work = {quot_work[QUOT_BITS-2:0], take};
         end
         rem_in[s]  = rem_work;
         quot_in[s] = quot_work;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (load[s]) begin
               valid_ff[s] <= src_valid[s];
            end
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      for (int s = 0; s < STAGES; s++) begin
         if (load[s] && src_valid[s]) begin
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= src_den[s];
            quot_ff[s] <= quot_in[s];
            quad_ff[s] <= src_quad[s];
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quot  = quot_ff[STAGES-1];
   assign out_quad  = quad_ff[STAGES-1];

   // Octant quotient stays within range away from the origin
   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_quad.origin |-> out_quot <= QUOT_BITS'(OCT_MAX))
      else $error("octant quotient out of range");

   // Final remainder is below the divisor, so no quotient bit was lost
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_quad.origin |-> rem_ff[STAGES-1] < NUM_W'(den_ff[STAGES-1]))
      else $error("divider remainder not reduced");

   // An accepted beat lands in the first stage
   a_beat_enters: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted beat lost at divider entry");

   // A full, stalled pipe takes nothing new
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (&valid_ff) && !out_ready |-> !in_ready)
      else $error("divider accepted a beat while full");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the integer atan2 (degrees) block.
module tb;
   import ia2d_pkg::*;

   localparam int  N_RANDOM   = 850;
   localparam int  HOLD_LEN   = 300;  // long output hold-off, in cycles
   localparam int  HOLD_AT    = 520;  // result count at which the hold-off starts
   localparam time RUN_LIMIT  = 4_000_000;

   localparam longint ANG_90  = longint'(DEG_90);
   localparam longint ANG_180 = longint'(DEG_180);
   localparam longint ANG_270 = longint'(DEG_270);
   localparam longint ANG_360 = longint'(DEG_360);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [ANGLE_W-1:0]        angle_type;

   typedef struct {
      coord_type y;
      coord_type x;
      angle_type angle;
   } point_rec_type;

   // Expected angles in arrival order, with the point that caused each one
   class angle_board_type;
      point_rec_type pending_q[$];
      int            checked;
      int            errors;

      function new();
         checked = 0;
         errors  = 0;
      endfunction

      // floor(a*(182b-47a)/(3b*b)) for 0 <= a <= b
      static function longint octant_deg(longint a, longint b);
         longint num;
         longint den;
         if (b <= 0) return 0;
         num = a * (OCT_B * b - OCT_A * a);
         den = DEN_GAIN * b * b;
         if (num < 0) return 0;
         return num / den;
      endfunction

      // Signed angle in -90..90 for the ratio p/q once the signs are folded
      static function longint folded_deg(longint p, longint q);
         longint sgn;
         longint r;
         sgn = 1;
         if (q < 0 && p < 0) begin
            p = -p;
            q = -q;
         end else if (q < 0) begin
            q   = -q;
            sgn = -1;
         end else if (p < 0) begin
            p   = -p;
            sgn = -1;
         end
         if (p > q) r = ANG_90 - octant_deg(q, p);
         else r = octant_deg(p, q);
         return sgn * r;
      endfunction

      static function angle_type predict_angle(coord_type y_in, coord_type x_in);
         longint y;
         longint x;
         longint ang;
         y = y_in;
         x = x_in;
         if (x == 0 && y == 0) ang = 0;
         else if (y > 0) ang = (ANG_90 - folded_deg(x, y) + ANG_360) % ANG_360;
         else if (y < 0) ang = (ANG_270 - folded_deg(x, y) + ANG_360) % ANG_360;
         else if (x < 0) ang = (ANG_180 + folded_deg(y, x)) % ANG_360;
         else ang = folded_deg(y, x);
         if (ang < 0) ang += ANG_360;
         return ANGLE_W'(ang);
      endfunction

      function void note_point(coord_type y, coord_type x);
         point_rec_type rec;
         rec.y     = y;
         rec.x     = x;
         rec.angle = predict_angle(y, x);
         pending_q.push_back(rec);
      endfunction

      function void check_angle(angle_type got);
         point_rec_type rec;
         if (pending_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: expected none, actual %0d",
                     $time, got);
            errors++;
            return;
         end
         rec = pending_q.pop_front();
         checked++;
         if (got !== rec.angle) begin
            $display("%0t: angle for (y=%0d, x=%0d): expected %0d, actual %0d",
                     $time, rec.y, rec.x, rec.angle, got);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic               clock         = 1'b0;
   logic               reset         = 1'b1;
   logic               req_valid     = 1'b0;
   logic               req_ready;
   logic [COORD_W-1:0] req_y_coord   = '0;
   logic [COORD_W-1:0] req_x_coord   = '0;
   logic               rsp_valid;
   logic               rsp_ready     = 1'b0;
   logic [ANGLE_W-1:0] rsp_angle_deg;

   angle_board_type board    = new();
   int              n_sent   = 0;
   int              n_direct = 0;
   int              n_rsp    = 0;

   integer_atan2_degrees uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_y_coord   (req_y_coord),
      .req_x_coord   (req_x_coord),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_angle_deg (rsp_angle_deg)
   );

   always #10 clock = ~clock;

   // Offer one point; gaps vanish in the burst windows so the pipe can fill
   task automatic send_point(input int y, input int x);
      int        gap;
      coord_type yb;
      coord_type xb;
      yb  = COORD_W'(y);
      xb  = COORD_W'(x);
      gap = $urandom_range(0, 19);
      if ((n_sent >= 200 && n_sent < 260) || (n_sent >= 480 && n_sent < 720)) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_y_coord <= yb;
      req_x_coord <= xb;
      do @(posedge clock); while (!req_ready);
      board.note_point(yb, xb);
      n_sent++;
   endtask

   function automatic int clamp_coord(int v);
      if (v > 2047) return 2047;
      if (v < -2048) return -2048;
      return v;
   endfunction

   task automatic send_directed();
      // origin and the four half axes
      send_point(0, 0);
      send_point(0, 5);
      send_point(0, -5);
      send_point(5, 0);
      send_point(-5, 0);
      send_point(0, 2047);
      send_point(0, -2048);
      send_point(2047, 0);
      send_point(-2048, 0);
      // corners, including the most negative value in both fields
      send_point(-2048, -2048);
      send_point(2047, 2047);
      send_point(-2048, 2047);
      send_point(2047, -2048);
      // just off the axes at full scale
      send_point(1, 2047);
      send_point(2047, 1);
      send_point(-1, -2048);
      send_point(-2048, -1);
      send_point(-1, 2047);
      send_point(-2048, 1);
      // diagonals in every quadrant
      send_point(7, 7);
      send_point(-7, 7);
      send_point(7, -7);
      send_point(-7, -7);
      send_point(1, -1);
      send_point(100, 173);
      n_direct = n_sent;
   endtask

   task automatic send_random();
      int kind;
      int y;
      int x;
      int mag;
      for (int i = 0; i < N_RANDOM; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            // whole range
            y = $signed(COORD_W'($urandom()));
            x = $signed(COORD_W'($urandom()));
         end else if (kind < 60) begin
            // tiny magnitudes, where truncation steps are coarse
            y = int'($urandom_range(0, 16)) - 8;
            x = int'($urandom_range(0, 16)) - 8;
         end else if (kind < 75) begin
            // close to a diagonal, exercising the swap boundary
            mag = $urandom_range(0, 2048);
            x   = $urandom_range(0, 1) ? mag : -mag;
            y   = ($urandom_range(0, 1) ? mag : -mag) + int'($urandom_range(0, 6)) - 3;
            x   = clamp_coord(x);
            y   = clamp_coord(y);
         end else if (kind < 88) begin
            // on or beside an axis
            mag = $signed(COORD_W'($urandom()));
            y   = int'($urandom_range(0, 4)) - 2;
            x   = mag;
            if ($urandom_range(0, 1)) begin
               x = y;
               y = mag;
            end
         end else begin
            // one coordinate at an extreme
            y = $urandom_range(0, 1) ? 2047 : -2048;
            x = $signed(COORD_W'($urandom()));
            if ($urandom_range(0, 1)) begin
               mag = x;
               x   = y;
               y   = mag;
            end
         end
         send_point(y, x);
      end
   endtask

   // Result side: random stalls, a stall-free stretch and one long hold-off
   initial begin
      int pause;
      @(negedge reset);
      forever begin
         pause = $urandom_range(0, 19);
         if (n_rsp >= 100 && n_rsp < 180) pause = 0;
         if (n_rsp == HOLD_AT) pause = HOLD_LEN;
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_angle(rsp_angle_deg);
         n_rsp++;
      end
   end

   // Main sequence
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_directed();
      send_random();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d points (%0d directed, the rest random, one long output hold-off).",
               n_sent, n_direct);
      $display("Checked %0d angles, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #RUN_LIMIT;
      $display("Timed out with %0d angles outstanding.", board.outstanding());
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
src/ia2d_pkg.sv
src/ia2d_div.sv
src/integer_atan2_degrees.sv
tb/tb.sv
